### design/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the motor feedback unwrap checkers.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, disabled while reset is held low.
`define MFAU_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// Clocked assertion that stays active during reset.
`define MFAU_ASSERT_RST(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

### design/mfau_pkg.sv
// ----------------------------------------------------------------------------
// mfau_pkg
// Constants and types for the motor feedback multi-turn angle unwrap.
// ----------------------------------------------------------------------------
package mfau_pkg;

  localparam int MOTORS_PER_BUS  = 7;
  localparam int BUS_COUNT       = 2;
  localparam int COUNTS_PER_TURN = 8192;
  localparam int ENTRY_COUNT     = MOTORS_PER_BUS * BUS_COUNT;

  localparam int ID_W     = 11;
  localparam int BUS_W    = 1;
  localparam int IDX_W    = 3;
  localparam int ENTRY_W  = $clog2(ENTRY_COUNT);
  localparam int ANGLE_W  = $clog2(COUNTS_PER_TURN);
  localparam int SPEED_W  = 16;
  localparam int CUR_W    = 16;
  localparam int TEMP_W   = 8;
  localparam int ROUND_W  = 16;
  localparam int TICK_W   = 32;
  localparam int TOTAL_W  = 40;
  localparam int STEP_W   = ANGLE_W + 2;

  // degrees per tick = 38805 / 2^24, total kept as Q.16 -> shift by 8
  localparam int SCALE_W     = 17;
  localparam int ANGLE_SCALE = 38805;
  localparam int SCALE_SHIFT = 8;
  localparam int PROD_W      = TICK_W + SCALE_W;

  localparam logic [ID_W-1:0] BASE_ID_RST = ID_W'(513);

  localparam logic signed [STEP_W-1:0] TURN_S = STEP_W'(COUNTS_PER_TURN);
  localparam logic signed [STEP_W-1:0] HALF_S = STEP_W'(COUNTS_PER_TURN / 2);

  localparam logic signed [ROUND_W-1:0] ROUND_MAX = {1'b0, {(ROUND_W-1){1'b1}}};
  localparam logic signed [ROUND_W-1:0] ROUND_MIN = {1'b1, {(ROUND_W-1){1'b0}}};

  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

  // One classified frame waiting for the unwrap stage
  typedef struct packed {
    logic [BUS_W-1:0]          bus;
    logic [IDX_W-1:0]          motor_index;
    logic [ENTRY_W-1:0]        entry;
    logic [ANGLE_W-1:0]        angle;
    logic signed [SPEED_W-1:0] speed;
    logic [CUR_W-1:0]          current;
    logic [TEMP_W-1:0]         temp;
  } mfau_item_t;

  // Front to queue push request
  typedef struct packed {
    logic       valid;
    mfau_item_t item;
  } mfau_push_t;

  // Queue to back head status
  typedef struct packed {
    logic       valid;
    mfau_item_t item;
  } mfau_head_t;

endpackage

### design/mfau_if.sv
// ----------------------------------------------------------------------------
// mfau channel interfaces
// Valid/ready channels for feedback frames, results and the base id write.
// ----------------------------------------------------------------------------
interface mfau_in_if import mfau_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic [BUS_W-1:0]          bus;
  logic [ID_W-1:0]           frame_id;
  logic [ANGLE_W-1:0]        angle_raw;
  logic signed [SPEED_W-1:0] speed_raw;
  logic [CUR_W-1:0]          current_raw;
  logic [TEMP_W-1:0]         temperature;

  modport source (output valid, bus, frame_id, angle_raw, speed_raw, current_raw,
                  temperature, input ready);
  modport sink   (input valid, bus, frame_id, angle_raw, speed_raw, current_raw,
                  temperature, output ready);
endinterface

interface mfau_out_if import mfau_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic [BUS_W-1:0]          out_bus;
  logic [IDX_W-1:0]          motor_index;
  logic [ANGLE_W-1:0]        angle;
  logic signed [SPEED_W-1:0] rotor_speed;
  logic [CUR_W-1:0]          current_code;
  logic [TEMP_W-1:0]         motor_temp;
  logic signed [ROUND_W-1:0] round_count;
  logic signed [TOTAL_W-1:0] shaft_angle;

  modport source (output valid, out_bus, motor_index, angle, rotor_speed, current_code,
                  motor_temp, round_count, shaft_angle, input ready);
  modport sink   (input valid, out_bus, motor_index, angle, rotor_speed, current_code,
                  motor_temp, round_count, shaft_angle, output ready);
endinterface

interface mfau_cfg_if import mfau_pkg::*; ();
  logic            valid;
  logic            ready;
  logic [ID_W-1:0] base_id;

  modport source (output valid, base_id, input ready);
  modport sink   (input valid, base_id, output ready);
endinterface

### design/mfau_front.sv
// ----------------------------------------------------------------------------
// mfau_front
// Holds base_id, matches frame ids to a motor entry, pushes matches to queue.
// ----------------------------------------------------------------------------
module mfau_front import mfau_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  mfau_in_if.sink     in_ch,
  mfau_cfg_if.sink    cfg_ch,
  input  logic        q_full,
  output mfau_push_t  push
);

  logic [ID_W-1:0] base_id_r;
  logic [ID_W:0]   id_diff;
  logic            id_hit;
  logic            bus_hit;

  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_id_r <= BASE_ID_RST;
    end else if (cfg_ch.valid) begin
      base_id_r <= cfg_ch.base_id;
    end
  end

  // borrow bit set means frame_id below base
  assign id_diff = {1'b0, in_ch.frame_id} - {1'b0, base_id_r};
  assign id_hit  = !id_diff[ID_W] && (32'(id_diff[ID_W-1:0]) < MOTORS_PER_BUS);
  assign bus_hit = 32'(in_ch.bus) < BUS_COUNT;

  // unmatched frames are taken and dropped
  assign in_ch.ready = !q_full;

  always_comb begin
    push.valid            = in_ch.valid && !q_full && id_hit && bus_hit;
    push.item.bus         = in_ch.bus;
    push.item.motor_index = id_diff[IDX_W-1:0];
    push.item.entry       = ENTRY_W'(in_ch.bus) * ENTRY_W'(MOTORS_PER_BUS)
                          + ENTRY_W'(id_diff[IDX_W-1:0]);
    push.item.angle       = in_ch.angle_raw;
    push.item.speed       = in_ch.speed_raw;
    push.item.current     = in_ch.current_raw;
    push.item.temp        = in_ch.temperature;
  end

endmodule

### design/mfau_queue.sv
// ----------------------------------------------------------------------------
// mfau_queue
// Short FIFO of classified frames between front and back.
// ----------------------------------------------------------------------------
module mfau_queue import mfau_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  mfau_push_t push,
  input  logic       pop,
  output logic       full,
  output mfau_head_t head
);

  mfau_item_t        slot_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_r;
  logic [QPTR_W-1:0] rd_ptr_r;
  logic [QPTR_W:0]   count_r;
  logic              do_pop;

  assign full       = (32'(count_r) == QUEUE_DEPTH);
  assign head.valid = (count_r != '0);
  assign head.item  = slot_r[rd_ptr_r];
  assign do_pop     = pop && head.valid;

  always_ff @(posedge clk) begin
    if (push.valid) begin
      slot_r[wr_ptr_r] <= push.item;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push.valid) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      if (push.valid && !do_pop) begin
        count_r <= count_r + 1'b1;
      end else if (!push.valid && do_pop) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

endmodule

### design/mfau_back.sv
// ----------------------------------------------------------------------------
// mfau_back
// Per-motor unwrap and tick update, then angle scaling into the result register.
// ----------------------------------------------------------------------------
module mfau_back import mfau_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  mfau_head_t head,
  output logic       pop,
  mfau_out_if.source out_ch
);

  // per-motor state
  logic [ANGLE_W-1:0]        prev_angle_r [ENTRY_COUNT];
  logic signed [ROUND_W-1:0] wrap_cnt_r   [ENTRY_COUNT];
  logic signed [TICK_W-1:0]  tick_tot_r   [ENTRY_COUNT];

  // unwrap stage
  logic signed [STEP_W-1:0]  diff;
  logic signed [STEP_W-1:0]  step;
  logic                      fwd_wrap;
  logic                      back_wrap;
  logic signed [ROUND_W-1:0] wrap_old;
  logic signed [ROUND_W-1:0] wrap_nxt;
  logic signed [TICK_W:0]    tick_sum;
  logic signed [TICK_W-1:0]  tick_nxt;

  // scale stage
  logic                      s2_valid_r;
  mfau_item_t                s2_item_r;
  logic signed [ROUND_W-1:0] s2_wrap_r;
  logic signed [TICK_W-1:0]  s2_tick_r;
  logic signed [PROD_W-1:0]  prod;

  // result register
  logic                      out_valid_r;
  mfau_item_t                out_item_r;
  logic signed [ROUND_W-1:0] out_wrap_r;
  logic signed [TOTAL_W-1:0] out_total_r;

  logic out_load;
  logic s2_free;

  assign out_load = s2_valid_r && (!out_valid_r || out_ch.ready);
  assign s2_free  = !s2_valid_r || out_load;
  assign pop      = head.valid && s2_free;

  // shorter step across the wrap, ties keep the direct difference
  always_comb begin
    diff      = $signed(STEP_W'(head.item.angle))
              - $signed(STEP_W'(prev_angle_r[head.item.entry]));
    fwd_wrap  = diff < -HALF_S;
    back_wrap = diff > HALF_S;
    wrap_old  = wrap_cnt_r[head.item.entry];
    step      = diff;
    wrap_nxt  = wrap_old;
    if (fwd_wrap) begin
      step = diff + TURN_S;
      if (wrap_old != ROUND_MAX) wrap_nxt = wrap_old + ROUND_W'(1);
    end else if (back_wrap) begin
      step = diff - TURN_S;
      if (wrap_old != ROUND_MIN) wrap_nxt = wrap_old - ROUND_W'(1);
    end
    tick_sum = (TICK_W+1)'(tick_tot_r[head.item.entry]) + (TICK_W+1)'(step);
    if (tick_sum[TICK_W] != tick_sum[TICK_W-1]) begin
      tick_nxt = {tick_sum[TICK_W], {(TICK_W-1){~tick_sum[TICK_W]}}};
    end else begin
      tick_nxt = tick_sum[TICK_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < ENTRY_COUNT; k++) begin
        prev_angle_r[k] <= '0;
        wrap_cnt_r[k]   <= '0;
        tick_tot_r[k]   <= '0;
      end
    end else if (pop) begin
      prev_angle_r[head.item.entry] <= head.item.angle;
      wrap_cnt_r[head.item.entry]   <= wrap_nxt;
      tick_tot_r[head.item.entry]   <= tick_nxt;
    end
  end

  // ticks * 38805 >>> 8, arithmetic shift gives the floor
  assign prod = $signed(PROD_W'(s2_tick_r)) * $signed(PROD_W'(ANGLE_SCALE));

  always_ff @(posedge clk) begin
    if (pop) begin
      s2_item_r <= head.item;
      s2_wrap_r <= wrap_nxt;
      s2_tick_r <= tick_nxt;
    end
    if (out_load) begin
      out_item_r  <= s2_item_r;
      out_wrap_r  <= s2_wrap_r;
      out_total_r <= prod[SCALE_SHIFT +: TOTAL_W];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (pop) begin
        s2_valid_r <= 1'b1;
      end else if (out_load) begin
        s2_valid_r <= 1'b0;
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.out_bus      = out_item_r.bus;
  assign out_ch.motor_index  = out_item_r.motor_index;
  assign out_ch.angle        = out_item_r.angle;
  assign out_ch.rotor_speed  = out_item_r.speed;
  assign out_ch.current_code = out_item_r.current;
  assign out_ch.motor_temp   = out_item_r.temp;
  assign out_ch.round_count  = out_wrap_r;
  assign out_ch.shaft_angle  = out_total_r;

endmodule

### design/motor_feedback_angle_unwrap.sv
// ----------------------------------------------------------------------------
// motor_feedback_angle_unwrap
// Multi-turn angle tracking for up to 2 x 7 motors from feedback frames.
// ----------------------------------------------------------------------------
// Takes one decoded feedback frame per transfer on in_ch and, when its
// identifier falls in base_id .. base_id+6, returns one result on out_ch for
// that motor: the raw fields passed through, a saturating wrap count and the
// accumulated shaft angle in degrees as signed Q.16 (ticks * 38805 >>> 8).
// Frames outside the window are taken and dropped without a result. The block
// takes one frame per clock for as long as its four-entry queue has room; a
// matching frame's result passes through the queue, the per-motor state
// update into the scale stage register and the scaling multiplier into the
// result register, and out_ch back-pressure can stall it. base_id must be
// written on cfg_ch by the user only while the block is idle; the block does
// not enforce this. Reset sets it to 513 and clears all per-motor state.
// ----------------------------------------------------------------------------
module motor_feedback_angle_unwrap import mfau_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  mfau_in_if.sink    in_ch,
  mfau_cfg_if.sink   cfg_ch,
  mfau_out_if.source out_ch
);

  mfau_push_t push;   // classified frame into the queue
  mfau_head_t head;   // oldest queued frame
  logic       q_full;
  logic       pop;

  // Front: base id register, window match, entry select.
  mfau_front u_front (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .cfg_ch (cfg_ch),
    .q_full (q_full),
    .push   (push)
  );

  // Decouples frame intake from output back-pressure.
  mfau_queue u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (push),
    .pop   (pop),
    .full  (q_full),
    .head  (head)
  );

  // Back: read-modify-write of the motor entry, then scaling into the
  // result register. Back-to-back frames for the same motor see the
  // update of the previous one since the write lands at the pop edge.
  mfau_back u_back (
    .clk    (clk),
    .rst_n  (rst_n),
    .head   (head),
    .pop    (pop),
    .out_ch (out_ch)
  );

endmodule

### design/mfau_checker.sv
// ----------------------------------------------------------------------------
// mfau_checker
// Port-level checks on the unwrap result channel, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module mfau_checker import mfau_pkg::*; (
  input logic                      clk,
  input logic                      rst_n,
  input logic                      out_valid,
  input logic                      out_ready,
  input logic [IDX_W-1:0]          motor_index,
  input logic signed [ROUND_W-1:0] round_count,
  input logic signed [TOTAL_W-1:0] shaft_angle
);

  localparam logic signed [TOTAL_W-1:0] TOTAL_MAX = TOTAL_W'(64'sd325519933440);
  localparam logic signed [TOTAL_W-1:0] TOTAL_MIN = TOTAL_W'(-64'sd325519933440);

  // stalled result holds its fields
  property p_hold;
    out_valid && !out_ready |=>
      out_valid && $stable(motor_index) && $stable(round_count) && $stable(shaft_angle);
  endproperty

  // tick total saturates, so the scaled angle stays in range
  property p_total;
    out_valid |-> shaft_angle <= TOTAL_MAX && shaft_angle >= TOTAL_MIN;
  endproperty

  `MFAU_ASSERT_RST(a_rst_idle, clk, !rst_n |=> !out_valid, "result valid after reset")

  `MFAU_ASSERT(a_hold, clk, rst_n, p_hold, "stalled result changed")

  `MFAU_ASSERT(a_index, clk, rst_n, out_valid |-> 32'(motor_index) < MOTORS_PER_BUS, "motor index out of window")

  `MFAU_ASSERT(a_total, clk, rst_n, p_total, "total angle beyond saturated range")

endmodule

bind motor_feedback_angle_unwrap mfau_checker u_mfau_checker (
  .clk         (clk),
  .rst_n       (rst_n),
  .out_valid   (out_ch.valid),
  .out_ready   (out_ch.ready),
  .motor_index (out_ch.motor_index),
  .round_count (out_ch.round_count),
  .shaft_angle (out_ch.shaft_angle)
);
